>>> rtl/m3i_pkg.sv
// shared types, widths, cofactor selection table and saturation helper
// for the 3x3 matrix inverse core; no dependencies
`timescale 1ns / 1ps

package m3i_pkg;

	localparam int EW  = 32;  // element width
	localparam int NEL = 9;   // elements per matrix
	localparam int PW  = 64;  // signed 32x32 product
	localparam int CFW = 65;  // signed cofactor
	localparam int CMW = 64;  // cofactor magnitude
	localparam int DMW = 97;  // determinant magnitude
	localparam int DW  = 98;  // signed determinant
	localparam int QW  = 32;  // quotient bits before rounding

	typedef logic signed [EW-1:0] elem_t;

	// minor a*d - b*c of each inverse element, row-major, with checkerboard sign
	typedef struct packed {
		logic [3:0] a;
		logic [3:0] d;
		logic [3:0] b;
		logic [3:0] c;
		logic       neg;
	} cof_sel_t;

	localparam cof_sel_t COF_TAB [NEL] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7, 1'b0},
		'{4'd1, 4'd8, 4'd2, 4'd7, 1'b1},
		'{4'd1, 4'd5, 4'd2, 4'd4, 1'b0},
		'{4'd3, 4'd8, 4'd5, 4'd6, 1'b1},
		'{4'd0, 4'd8, 4'd2, 4'd6, 1'b0},
		'{4'd0, 4'd5, 4'd2, 4'd3, 1'b1},
		'{4'd3, 4'd7, 4'd4, 4'd6, 1'b0},
		'{4'd0, 4'd7, 4'd1, 4'd6, 1'b1},
		'{4'd0, 4'd4, 4'd1, 4'd3, 1'b0}
	};

	localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_NEG = 32'h8000_0000;

	// magnitude plus sign to a saturated 32-bit two's complement word
	function automatic logic [31:0] sat32(input logic [32:0] mag, input logic neg);
		logic [32:0] nm;
		nm = 33'd0 - mag;
		if (neg) begin
			if (mag > 33'h0_8000_0000)
				return SAT_NEG;
			return nm[31:0];
		end
		if (mag > 33'h0_7FFF_FFFF)
			return SAT_POS;
		return mag[31:0];
	endfunction

endpackage

>>> rtl/matrix3_inverse_determinant_core.sv
// 3x3 matrix inverse and determinant in signed fixed point
// top level: input register, nine cofactor lanes, determinant merge, nine divider lanes
// depends on m3i_pkg, m3i_cof_lane, m3i_det, m3i_div_lane
//
// usage:
//   s_tdata carries one matrix a word, nine signed elements row-major, r1c1 lowest.
//   m_tdata carries the nine inverse elements row-major then the determinant;
//   m_tuser flags a singular matrix, in which case every field is zero.
//   the pipeline is 43 register stages. throughput is one matrix a cycle while
//   the output is not stalled. each divider lane resolves one quotient bit a stage,
//   32 stages deep, and that chain sets the depth.
//   the whole pipeline advances together; when the receiver holds m_tready low
//   with a word waiting, every stage holds and s_tready falls in the same cycle,
//   so no word is lost. bubbles move on while the output register is empty.
//   reset clears the valid bits only; the pipeline comes up empty.
`timescale 1ns / 1ps

module matrix3_inverse_determinant_core
	import m3i_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	// r1c1, r1c2, r1c3, r2c1, r2c2, r2c3, r3c1, r3c2, r3c3 (32 bits each)
	input  logic [287:0]   s_tdata,
	output logic           m_tvalid,
	input  logic           m_tready,
	// inv_r1c1 .. inv_r3c3 row-major, then det_value (32 bits each)
	output logic [319:0]   m_tdata,
	// singular
	output logic [0:0]     m_tuser
);

	localparam int DIV_IN = 8;
	localparam int NSTG   = DIV_IN + QW + 3;
	localparam int DLY    = NSTG - 9;

	logic            en;
	logic [NSTG-1:0] vld_s;
	elem_t           m_s1 [NEL];

	logic [CMW-1:0] cmag_s4 [NEL], cmag_s8 [NEL];
	logic           cneg_s4 [NEL], cneg_s8 [NEL];
	logic [DMW-1:0] dmag_s8;
	logic           dneg_s8, dzero_s8;
	logic [31:0]    det_s9;
	logic           sing_s9;
	logic [31:0]    q_s43 [NEL];
	logic [31:0]    det_dl_s [DLY];
	logic           sing_dl_s [DLY];
	elem_t          col [3];
	logic [CMW-1:0] dcm [3];
	logic           dcn [3];

	assign en       = !vld_s[NSTG-1] || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSTG-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NEL; k++)
				m_s1[k] <= s_tdata[k*EW +: EW];
			det_dl_s[0]  <= det_s9;
			sing_dl_s[0] <= sing_s9;
			for (int i = 1; i < DLY; i++) begin
				det_dl_s[i]  <= det_dl_s[i-1];
				sing_dl_s[i] <= sing_dl_s[i-1];
			end
		end
	end

	for (genvar k = 0; k < NEL; k++) begin : g_lane
		m3i_cof_lane u_cof (
			.clk     (clk),
			.en      (en),
			.a       (m_s1[COF_TAB[k].a]),
			.d       (m_s1[COF_TAB[k].d]),
			.b       (m_s1[COF_TAB[k].b]),
			.c       (m_s1[COF_TAB[k].c]),
			.neg     (COF_TAB[k].neg),
			.cmag_s4 (cmag_s4[k]),
			.cneg_s4 (cneg_s4[k]),
			.cmag_s8 (cmag_s8[k]),
			.cneg_s8 (cneg_s8[k])
		);

		m3i_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk   (clk),
			.en    (en),
			.cmag  (cmag_s8[k]),
			.cneg  (cneg_s8[k]),
			.dmag  (dmag_s8),
			.dneg  (dneg_s8),
			.dzero (dzero_s8),
			.q_s43 (q_s43[k])
		);

		assign m_tdata[k*32 +: 32] = q_s43[k];
	end

	// expansion down the first column uses the cofactors of r1c1, r2c1, r3c1
	for (genvar j = 0; j < 3; j++) begin : g_col
		assign col[j] = m_s1[3*j];
		assign dcm[j] = cmag_s4[j];
		assign dcn[j] = cneg_s4[j];
	end

	m3i_det #(.FRAC_BITS(FRAC_BITS)) u_det (
		.clk      (clk),
		.en       (en),
		.col      (col),
		.cmag     (dcm),
		.cneg     (dcn),
		.dmag_s8  (dmag_s8),
		.dneg_s8  (dneg_s8),
		.dzero_s8 (dzero_s8),
		.det_s9   (det_s9),
		.sing_s9  (sing_s9)
	);

	assign m_tdata[NEL*32 +: 32] = det_dl_s[DLY-1];
	assign m_tuser[0]            = sing_dl_s[DLY-1];
	assign m_tvalid              = vld_s[NSTG-1];

`ifndef SYNTH
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("singular word carries nonzero data");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_s[0])
		else $error("accepted word missing from first stage");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		en && !vld_s[NSTG-2] |=> !m_tvalid)
		else $error("output valid without a word behind it");
`endif

endmodule

>>> rtl/m3i_cof_lane.sv
// one cofactor lane: 2x2 minor with sign, magnitude and a delay line to the divider
// depends on m3i_pkg
`timescale 1ns / 1ps

module m3i_cof_lane
	import m3i_pkg::*;
(
	input  logic           clk,
	input  logic           en,
	input  elem_t          a,
	input  elem_t          d,
	input  elem_t          b,
	input  elem_t          c,
	input  logic           neg,
	output logic [CMW-1:0] cmag_s4,
	output logic           cneg_s4,
	output logic [CMW-1:0] cmag_s8,
	output logic           cneg_s8
);

	localparam int DLY = 4;

	logic signed [PW-1:0]  p0, p1;
	logic signed [PW-1:0]  p0_s2, p1_s2;
	logic signed [CFW-1:0] diff;
	logic signed [CFW-1:0] cof_s3;
	logic        [CFW-1:0] cabs;
	logic [CMW-1:0] mag_s [DLY];
	logic           sgn_s [DLY];

	assign p0   = a * d;
	assign p1   = b * c;
	assign diff = CFW'(p0_s2) - CFW'(p1_s2);
	assign cabs = cof_s3[CFW-1] ? CFW'(-cof_s3) : CFW'(cof_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s2   <= p0;
			p1_s2   <= p1;
			cof_s3  <= neg ? -diff : diff;
			cmag_s4 <= cabs[CMW-1:0];
			cneg_s4 <= cof_s3[CFW-1];
			mag_s[0] <= cmag_s4;
			sgn_s[0] <= cneg_s4;
			for (int i = 1; i < DLY; i++) begin
				mag_s[i] <= mag_s[i-1];
				sgn_s[i] <= sgn_s[i-1];
			end
		end
	end

	assign cmag_s8 = mag_s[DLY-1];
	assign cneg_s8 = sgn_s[DLY-1];

endmodule

>>> rtl/m3i_det.sv
// merging stage: determinant from the first column and its cofactors,
// rounded and saturated copy for the output; depends on m3i_pkg
`timescale 1ns / 1ps

module m3i_det
	import m3i_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           en,
	input  elem_t          col [3],
	input  logic [CMW-1:0] cmag [3],
	input  logic           cneg [3],
	output logic [DMW-1:0] dmag_s8,
	output logic           dneg_s8,
	output logic           dzero_s8,
	output logic [31:0]    det_s9,
	output logic           sing_s9
);

	localparam int SH = 2 * FRAC_BITS;
	localparam int TW = DMW - SH + 1;

	elem_t a_s2 [3], a_s3 [3], a_s4 [3];
	logic [31:0]          amag [3];
	logic [63:0]          plo_s5 [3], phi_s5 [3];
	logic                 tneg_s5 [3];
	logic [95:0]          tmag [3];
	logic signed [DW-1:0] term_s6 [3];
	logic signed [DW-1:0] det_s7;
	logic [DW-1:0]        dabs;
	logic [TW-1:0]        tr;
	logic [32:0]          mag33;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			amag[k] = a_s4[k][EW-1] ? 32'(-a_s4[k]) : 32'(a_s4[k]);
			tmag[k] = {phi_s5[k], 32'd0} + 96'(plo_s5[k]);
		end
	end

	assign dabs  = det_s7[DW-1] ? DW'(-det_s7) : DW'(det_s7);
	assign tr    = TW'(dmag_s8 >> SH) + TW'(dmag_s8[SH-1]);
	assign mag33 = (|tr[TW-1:33]) ? {33{1'b1}} : tr[32:0];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				a_s2[k]    <= col[k];
				a_s3[k]    <= a_s2[k];
				a_s4[k]    <= a_s3[k];
				plo_s5[k]  <= amag[k] * cmag[k][31:0];
				phi_s5[k]  <= amag[k] * cmag[k][63:32];
				tneg_s5[k] <= a_s4[k][EW-1] ^ cneg[k];
				term_s6[k] <= tneg_s5[k] ? -$signed(DW'(tmag[k])) : $signed(DW'(tmag[k]));
			end
			det_s7   <= term_s6[0] + term_s6[1] + term_s6[2];
			dmag_s8  <= dabs[DMW-1:0];
			dneg_s8  <= det_s7[DW-1];
			dzero_s8 <= (det_s7 == '0);
			det_s9   <= dzero_s8 ? 32'd0 : sat32(mag33, dneg_s8);
			sing_s9  <= dzero_s8;
		end
	end

endmodule

>>> rtl/m3i_div_lane.sv
// one divider lane: restoring division one quotient bit a stage,
// round half away from zero and saturate; depends on m3i_pkg
`timescale 1ns / 1ps

module m3i_div_lane
	import m3i_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           en,
	input  logic [CMW-1:0] cmag,
	input  logic           cneg,
	input  logic [DMW-1:0] dmag,
	input  logic           dneg,
	input  logic           dzero,
	output logic [31:0]    q_s43
);

	localparam int SH = 2 * FRAC_BITS;
	localparam int NW = CMW + SH;
	localparam int CW = ((NW > DMW + QW) ? NW : DMW + QW) + 1;

	logic [NW-1:0]  rem_s [QW+1];
	logic [DMW-1:0] den_s [QW+1];
	logic [QW-1:0]  quo_s [QW+1];
	logic           ovf_s [QW+1];
	logic           sg_s  [QW+1];
	logic           z_s   [QW+1];
	logic [NW-1:0]  num;
	logic [32:0]    qr_s42;
	logic           ovf_s42, sg_s42, z_s42, rnd;

	assign num = {cmag, {SH{1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= dmag;
			quo_s[0] <= '0;
			// quotient would not fit in QW bits: saturates whatever the sign
			ovf_s[0] <= (CW'(num) >= (CW'(dmag) << QW));
			sg_s[0]  <= cneg ^ dneg;
			z_s[0]   <= dzero;
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_step
		localparam int K = QW - 1 - i;
		logic [CW-1:0] dsh, dif;
		logic          ge;
		assign dsh = CW'(den_s[i]) << K;
		assign ge  = CW'(rem_s[i]) >= dsh;
		assign dif = CW'(rem_s[i]) - dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? dif[NW-1:0] : rem_s[i];
				quo_s[i+1] <= quo_s[i] | (QW'(ge) << K);
				den_s[i+1] <= den_s[i];
				ovf_s[i+1] <= ovf_s[i];
				sg_s[i+1]  <= sg_s[i];
				z_s[i+1]   <= z_s[i];
			end
		end
	end

	// twice the remainder against the divisor decides the round-up
	assign rnd = CW'({rem_s[QW], 1'b0}) >= CW'(den_s[QW]);

	always_ff @(posedge clk) begin
		if (en) begin
			qr_s42  <= {1'b0, quo_s[QW]} + 33'(rnd);
			ovf_s42 <= ovf_s[QW];
			sg_s42  <= sg_s[QW];
			z_s42   <= z_s[QW];
			if (z_s42)
				q_s43 <= 32'd0;
			else if (ovf_s42)
				q_s43 <= sg_s42 ? SAT_NEG : SAT_POS;
			else
				q_s43 <= sat32(qr_s42, sg_s42);
		end
	end

endmodule

>>> dv/testbench.sv
// self-checking bench for matrix3_inverse_determinant_core: drives matrices,
// predicts inverse, determinant and singular flag with a wide-integer model
// depends on m3i_pkg and the core rtl
`timescale 1ns / 1ps

module testbench
	import m3i_pkg::*;
();

	localparam int FRAC = 16;
	localparam int LATENCY = 42;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic [319:0] data;
		logic         sing;
	} inv_word_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [287:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [319:0] m_tdata;
	logic [0:0] m_tuser;

	inv_word_t inverse_q[$];
	int errors;
	int words_sent;
	int words_seen;
	int singular_seen;
	longint cycle_count;
	bit hold_off_req;
	bit hold_off_done;

	matrix3_inverse_determinant_core #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// magnitude + sign to a saturated 32-bit word
	function automatic logic [31:0] sat_word(logic [195:0] mag, logic neg);
		if (neg) begin
			if (mag > 196'h8000_0000)
				return SAT_NEG;
			return 32'(-mag);
		end
		if (mag > 196'h7FFF_FFFF)
			return SAT_POS;
		return mag[31:0];
	endfunction

	function automatic inv_word_t predict_inverse(logic [287:0] mat);
		inv_word_t r;
		logic signed [199:0] m [9];
		logic signed [199:0] cof [9];
		logic signed [199:0] det;
		logic [195:0] dmag, nmag, q, rem, t;
		logic dneg;
		for (int k = 0; k < 9; k++)
			m[k] = $signed(mat[k*32 +: 32]);
		for (int k = 0; k < 9; k++) begin
			cof[k] = m[COF_TAB[k].a] * m[COF_TAB[k].d] - m[COF_TAB[k].b] * m[COF_TAB[k].c];
			if (COF_TAB[k].neg)
				cof[k] = -cof[k];
		end
		det = m[0] * cof[0] + m[3] * cof[1] + m[6] * cof[2];
		r.data = '0;
		r.sing = 1'b0;
		if (det == 0) begin
			r.sing = 1'b1;
			return r;
		end
		dneg = det < 0;
		dmag = dneg ? 196'(-det) : 196'(det);
		t = (dmag >> (2 * FRAC)) + ((dmag >> (2 * FRAC - 1)) & 196'd1);
		r.data[9*32 +: 32] = sat_word(t, dneg);
		for (int k = 0; k < 9; k++) begin
			nmag = cof[k] < 0 ? 196'(-cof[k]) : 196'(cof[k]);
			nmag = nmag << (2 * FRAC);
			q = nmag / dmag;
			rem = nmag % dmag;
			if ((rem << 1) >= dmag)
				q = q + 1;
			r.data[k*32 +: 32] = sat_word(q, (cof[k] < 0) != dneg);
		end
		return r;
	endfunction

	task automatic send_matrix(logic [287:0] mat);
		s_tvalid <= 1'b1;
		s_tdata  <= mat;
		inverse_q.push_back(predict_inverse(mat));
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
		// sender bursts: occasional gaps of random length
		if ($urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 6))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 4) << 16;
			3: return 32'(($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(0, 8)) <<< 16);
			4: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
			5: return 32'($signed($urandom_range(0, 32'hFF)) - 32'sh80);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [287:0] rand_matrix();
		logic [287:0] mat;
		for (int k = 0; k < 9; k++)
			mat[k*32 +: 32] = rand_elem();
		// force a dependent row now and then for singular cases
		if ($urandom_range(0, 7) == 0)
			mat[6*32 +: 96] = mat[0 +: 96];
		return mat;
	endfunction

	function automatic logic [287:0] diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		logic [287:0] mat;
		mat = '0;
		mat[0 +: 32] = a;
		mat[4*32 +: 32] = b;
		mat[8*32 +: 32] = c;
		return mat;
	endfunction

	task automatic test_directed();
		logic [287:0] mat;
		send_matrix(diag(32'h1_0000, 32'h1_0000, 32'h1_0000));
		send_matrix(diag(32'h2_0000, 32'hFFFF_0000, 32'h0_8000));
		send_matrix('0);
		send_matrix({9{32'h1_0000}});
		send_matrix({9{32'hFFFF_FFFF}});
		send_matrix({9{32'h8000_0000}});
		send_matrix({9{32'h7FFF_FFFF}});
		send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_matrix(diag(32'd1, 32'd1, 32'd1));
		send_matrix(diag(32'd1, 32'h1_0000, 32'h1_0000));
		send_matrix(diag(32'h3_0000, 32'h3_0000, 32'h3_0000));
		send_matrix(diag(32'h0_8000, 32'h1_0000, 32'h1_0000));
		mat = diag(32'h1_0000, 32'h1_0000, 32'h1_0000);
		mat[1*32 +: 32] = 32'h8000_0000;
		mat[5*32 +: 32] = 32'h7FFF_FFFF;
		send_matrix(mat);
		send_matrix({32'h1_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'h2_0000, 32'h3_0000});
		send_matrix({32'h9_0000, 32'h8_0000, 32'h7_0000, 32'h6_0000, 32'h5_0000,
			32'h4_0000, 32'h3_0000, 32'h2_0000, 32'h1_0000});
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_random(int count);
		repeat (count) send_matrix(rand_matrix());
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_backpressure();
		hold_off_req = 1'b1;
		repeat (150) send_matrix(rand_matrix());
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (hold_off_done);
	endtask

	// receiver: own stall pattern, plus one long hold-off on request
	initial begin
		int phase;
		m_tready = 1'b0;
		hold_off_done = 1'b0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_off_done) begin
				m_tready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off_done = 1'b1;
			end
			phase = (phase + 1) % 64;
			if (phase < 20)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// result check against the oldest prediction
	always @(posedge clk) begin
		inv_word_t exp_w;
		if (arst_n && m_tvalid && m_tready) begin
			words_seen++;
			if (m_tuser[0])
				singular_seen++;
			if (inverse_q.size() == 0) begin
				$display("%0t unexpected word: data %h singular %b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				exp_w = inverse_q.pop_front();
				for (int k = 0; k < 10; k++)
					if (m_tdata[k*32 +: 32] !== exp_w.data[k*32 +: 32]) begin
						$display("%0t field %0d mismatch: expected %h actual %h", $time, k,
							exp_w.data[k*32 +: 32], m_tdata[k*32 +: 32]);
						errors++;
					end
				if (m_tuser[0] !== exp_w.sing) begin
					$display("%0t singular mismatch: expected %b actual %b", $time,
						exp_w.sing, m_tuser[0]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		errors = 0;
		words_sent = 0;
		words_seen = 0;
		singular_seen = 0;
		cycle_count = 0;
		hold_off_req = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(1700);
		while (inverse_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("sent %0d matrices, checked %0d results, %0d singular, %0d errors",
			words_sent, words_seen, singular_seen, errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
